// File: rtl/rlma_pkg.sv
// rlma_pkg: shared types and constants of the rate limiter / moving average block
// no dependencies; compiled first
package rlma_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int RATE_W     = 31;
    localparam int WIN_CFG_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int MIN_WINDOW = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    // configuration register indexes
    localparam cfg_idx_t CFG_FILTER_MODE = 2'd0;
    localparam cfg_idx_t CFG_RATE_STEP   = 2'd1;
    localparam cfg_idx_t CFG_WINDOW_SIZE = 2'd2;

    // operation codes
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_FORCE = 1'b1;

    // filter modes
    localparam logic MODE_LIMIT = 1'b0;
    localparam logic MODE_AVG   = 1'b1;

endpackage

// File: rtl/rlma_if.sv
// rlma_if: valid/ready channel interfaces for samples and filter results
// depends on rlma_pkg
interface rlma_sample_if;
    import rlma_pkg::*;

    logic    valid;
    logic    ready;
    logic    operation;
    sample_t sample;

    modport source (output valid, output operation, output sample, input ready);
    modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface rlma_result_if;
    import rlma_pkg::*;

    logic    valid;
    logic    ready;
    sample_t filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

// File: rtl/rate_limit_or_moving_average_top.sv
// rate_limit_or_moving_average_top: two-mode sample filter, top level
// depends on rlma_pkg, rlma_if, rlma_hist_mem and rlma_div
//
// usage
//   sample_ch (sink) takes one transaction per item: operation and a signed sample.
//   result_ch (source) gives exactly one transaction per item: the filter output.
//   cfg_we/cfg_index/cfg_data write filter_mode, rate_step and window_size; write
//   them only while no item is in flight. a mode or window write clears the
//   history, the running sum and the output, just like reset.
// processing
//   one item is processed at a time. a limiter step or a force item goes from
//   acceptance into the last-output register and through ST_OUT to the result
//   register. a moving-average step runs the history read, then the sum's
//   read-modify-write, then the serial divider that produces one quotient bit per
//   cycle over the SUM_W-bit sum; the next item is accepted once back in ST_IDLE.
// reset and stalls
//   reset (rst_n, async, active low) leaves the block as if zero had been
//   forced. no clearing pass: a fill count marks the history entries written
//   since the last force, all others read as the forced value.
//   the result sits in an output register; a new item is accepted while it waits,
//   and that item's result is held internally until the register frees up.
module rate_limit_or_moving_average_top #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    rlma_sample_if.sink                        sample_ch,
    rlma_result_if.source                      result_ch,
    input  logic                               cfg_we,
    input  rlma_pkg::cfg_idx_t                 cfg_index,
    input  logic [rlma_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rlma_pkg::*;

    // widths that follow from the deepest window
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + AW;
    localparam int PW    = SAMPLE_W + WW + 1;

    typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_DIV_GO, ST_DIV_WAIT, ST_OUT} state_t;

    // control and configuration
    state_t            state_reg, state_next;
    logic              mode_reg, mode_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [WW-1:0]     win_reg, win_next;          // clamped window length

    // filter state
    logic signed [SUM_W-1:0] sum_reg, sum_next;     // running sum
    logic [AW-1:0]           slot_reg, slot_next;   // write slot
    logic [WW-1:0]           fill_reg, fill_next;   // entries written since force
    sample_t                 fillval_reg, fillval_next;
    sample_t                 last_reg, last_next;   // last output
    sample_t                 smp_reg, smp_next;     // sample in flight

    // output register
    logic    out_valid_reg, out_valid_next;
    sample_t out_data_reg, out_data_next;

    // datapath
    logic                    accept;
    logic [AW-1:0]           cur_slot;
    logic [WW-1:0]           slot_inc;
    logic signed [SAMPLE_W:0] diff, r_ext, y_lim;
    logic signed [PW-1:0]    force_prod;
    logic [31:0]             win_cfg32;
    sample_t                 old_val;

    // memory and divider hookup
    logic    mem_we, mem_re;
    sample_t mem_rdata;
    logic    div_start, div_done;
    sample_t div_quot;

    assign accept          = sample_ch.valid && sample_ch.ready;
    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign result_ch.valid    = out_valid_reg;
    assign result_ch.filtered = out_data_reg;

    // slot wraps if it ever sits past the window
    assign cur_slot = (WW'(slot_reg) >= win_reg) ? '0 : slot_reg;
    assign slot_inc = WW'(slot_reg) + 1'b1;

    // slew limiter on 33 bits so the difference never wraps
    assign r_ext = $signed({2'b00, rate_reg});
    assign diff  = $signed({sample_ch.sample[SAMPLE_W-1], sample_ch.sample})
                 - $signed({last_reg[SAMPLE_W-1], last_reg});

    always_comb
    begin
        if (diff > r_ext)
        begin
            y_lim = $signed({last_reg[SAMPLE_W-1], last_reg}) + r_ext;
        end
        else if (diff < -r_ext)
        begin
            y_lim = $signed({last_reg[SAMPLE_W-1], last_reg}) - r_ext;
        end
        else
        begin
            y_lim = $signed({sample_ch.sample[SAMPLE_W-1], sample_ch.sample});
        end
    end

    assign force_prod = sample_ch.sample * $signed({1'b0, win_reg});

    // entries not yet written since the last force read as the forced value
    assign old_val = (WW'(slot_reg) < fill_reg) ? mem_rdata : fillval_reg;

    assign win_cfg32 = 32'(cfg_data[WIN_CFG_W-1:0]);

    assign mem_re    = accept && (sample_ch.operation == OP_STEP) && (mode_reg == MODE_AVG);
    assign mem_we    = (state_reg == ST_READ);
    assign div_start = (state_reg == ST_DIV_GO);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        rate_next      = rate_reg;
        win_next       = win_reg;
        sum_next       = sum_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        fillval_next   = fillval_reg;
        last_next      = last_reg;
        smp_next       = smp_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // result taken by the receiver
        if (out_valid_reg && result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sample_ch.operation == OP_FORCE)
                    begin
                        // force: output, history and sum all take the sample
                        last_next    = sample_ch.sample;
                        fillval_next = sample_ch.sample;
                        fill_next    = '0;
                        slot_next    = '0;
                        sum_next     = force_prod[SUM_W-1:0];
                        state_next   = ST_OUT;
                    end
                    else if (mode_reg == MODE_LIMIT)
                    begin
                        last_next  = y_lim[SAMPLE_W-1:0];
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        // history read issued this cycle
                        smp_next   = sample_ch.sample;
                        slot_next  = cur_slot;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // read-modify-write of the sum, new sample goes into the slot
                sum_next = sum_reg + SUM_W'(smp_reg) - SUM_W'(old_val);
                slot_next = (slot_inc >= win_reg) ? '0 : slot_inc[AW-1:0];
                if (WW'(slot_reg) >= fill_reg)
                begin
                    fill_next = WW'(slot_reg) + 1'b1;
                end
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    last_next  = div_quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration writes must arrive only while idle; the block does not enforce this
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILTER_MODE:
                begin
                    mode_next    = cfg_data[0];
                    sum_next     = '0;
                    slot_next    = '0;
                    fill_next    = '0;
                    fillval_next = '0;
                    last_next    = '0;
                end
                CFG_RATE_STEP:
                begin
                    rate_next = cfg_data[RATE_W-1:0];
                end
                CFG_WINDOW_SIZE:
                begin
                    if (win_cfg32 < 32'(MIN_WINDOW))
                    begin
                        win_next = WW'(MIN_WINDOW);
                    end
                    else if (win_cfg32 > 32'(MAX_WINDOW))
                    begin
                        win_next = WW'(MAX_WINDOW);
                    end
                    else
                    begin
                        win_next = WW'(win_cfg32);
                    end
                    sum_next     = '0;
                    slot_next    = '0;
                    fill_next    = '0;
                    fillval_next = '0;
                    last_next    = '0;
                end
                default:
                begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_LIMIT;
            rate_reg      <= '0;
            win_reg       <= WW'(MIN_WINDOW);
            sum_reg       <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            fillval_reg   <= '0;
            last_reg      <= '0;
            smp_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            rate_reg      <= rate_next;
            win_reg       <= win_next;
            sum_reg       <= sum_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            fillval_reg   <= fillval_next;
            last_reg      <= last_next;
            smp_reg       <= smp_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // history of samples for the moving average
    rlma_hist_mem #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_hist (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot_reg),
        .wdata (smp_reg),
        .re    (mem_re),
        .raddr (cur_slot),
        .rdata (mem_rdata)
    );

    // sum / window, truncated toward zero
    rlma_div #(
        .SUM_W (SUM_W),
        .WW    (WW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (win_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

endmodule

// File: rtl/rlma_hist_mem.sv
// rlma_hist_mem: sample history memory, one write port, one read port
// registered read data; depends on rlma_pkg
module rlma_hist_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  rlma_pkg::sample_t        wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output rlma_pkg::sample_t        rdata
);
    import rlma_pkg::*;

    sample_t mem [DEPTH];
    sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/rlma_div.sv
// rlma_div: serial signed divide of the running sum by the window length
// one quotient bit per cycle, truncates toward zero; depends on rlma_pkg
module rlma_div #(
    parameter int SUM_W = 40,
    parameter int WW    = 9
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [WW-1:0]           divisor,
    output logic                    done,
    output rlma_pkg::sample_t       quotient
);
    import rlma_pkg::*;

    localparam int CW = $clog2(SUM_W + 1);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    dstate_t          state_reg, state_next;
    logic             neg_reg, neg_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [WW-1:0]    rem_reg, rem_next;
    logic [WW-1:0]    div_reg, div_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             done_reg, done_next;
    sample_t          res_reg, res_next;
    logic [WW:0]      trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    neg_next   = dividend[SUM_W-1];
                    quo_next   = dividend[SUM_W-1] ? -dividend : dividend;
                    rem_next   = '0;
                    div_next   = divisor;
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next = fits ? WW'(trial - {1'b0, div_reg}) : trial[WW-1:0];
                quo_next = {quo_reg[SUM_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SUM_W - 1))
                begin
                    state_next = D_FIN;
                end
            end
            D_FIN:
            begin
                res_next   = neg_reg ? -$signed(quo_reg[SAMPLE_W-1:0])
                                     : $signed(quo_reg[SAMPLE_W-1:0]);
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
            cnt_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            neg_reg   <= neg_next;
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            div_reg   <= div_next;
            cnt_reg   <= cnt_next;
            res_reg   <= res_next;
        end
    end

    assign done     = done_reg;
    assign quotient = res_reg;

endmodule

// File: tb/rate_limit_or_moving_average_top_tb.sv
// rate_limit_or_moving_average_top_tb: self-checking bench for the two-mode sample filter
// depends on rlma_pkg, rlma_if and rate_limit_or_moving_average_top
// a behavioral predictor tracks the filter state and checks every result transaction
module rate_limit_or_moving_average_top_tb;
    import rlma_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int HIST_DEPTH     = 256;
    localparam int TOTAL_ITEMS    = 1200;
    // settle time before a register write and after the last result
    localparam int IDLE_PAUSE     = 4;
    localparam int DRAIN_CYCLES   = 60;
    // slowest legal run: 1200 items, each with a full divide, the longest gap and heavy stall
    localparam int TIMEOUT_CYCLES = 1000000;
    // long receiver hold-off so the block backs up and stalls its input
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_SPACING   = 600;
    localparam int MAX_REPORTS    = 10;

    // register index that the block does not decode
    localparam cfg_idx_t CFG_UNDECODED = 2'd3;

    localparam sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam sample_t SAMPLE_MIN = 32'sh8000_0000;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    typedef struct packed {
        logic    operation;
        sample_t sample;
    } sample_txn_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rlma_sample_if sample_bus ();
    rlma_result_if result_bus ();

    rate_limit_or_moving_average_top #(
        .MAX_WINDOW (HIST_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_bus),
        .result_ch (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD/2) clk = ~clk;

    // ------------------------------------------------------------------
    // filter predictor: own copy of registers, history, sum and output
    // ------------------------------------------------------------------
    logic              cur_mode;
    logic [RATE_W-1:0] cur_rate;
    logic [WIN_CFG_W-1:0] cur_window;
    sample_t           hist_mem [HIST_DEPTH];
    longint            run_sum;
    int unsigned       wr_slot;
    sample_t           last_out;

    // window register clamped to the range the history supports
    function automatic int unsigned active_window();
        int unsigned n;
        n = cur_window;
        if (n < MIN_WINDOW)
            n = MIN_WINDOW;
        if (n > HIST_DEPTH)
            n = HIST_DEPTH;
        return n;
    endfunction

    // a force fills the whole history and rebuilds the sum from it
    function automatic void force_history(sample_t v);
        last_out = v;
        for (int k = 0; k < HIST_DEPTH; k++)
            hist_mem[k] = v;
        run_sum = longint'(v) * longint'(active_window());
        wr_slot = 0;
    endfunction

    function automatic void apply_register_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FILTER_MODE:
            begin
                cur_mode = data[0];
                force_history('0);
            end
            CFG_RATE_STEP:
                cur_rate = data[RATE_W-1:0];
            CFG_WINDOW_SIZE:
            begin
                cur_window = data[WIN_CFG_W-1:0];
                force_history('0);
            end
            default:
                ;
        endcase
    endfunction

    // advance the predictor by one accepted sample, return the expected output
    function automatic sample_t next_filtered(logic op, sample_t s);
        longint y;
        longint r;
        longint d;
        int unsigned n;
        if (op == OP_FORCE)
        begin
            force_history(s);
        end
        else if (cur_mode == MODE_LIMIT)
        begin
            // difference at full width, so the step never wraps
            y = longint'(last_out);
            r = longint'(cur_rate);
            d = longint'(s) - y;
            if (d > r)
                y = y + r;
            else if (d < -r)
                y = y - r;
            else
                y = longint'(s);
            last_out = sample_t'(y);
        end
        else
        begin
            n = active_window();
            if (wr_slot >= n)
                wr_slot = 0;
            run_sum = run_sum + longint'(s) - longint'(hist_mem[wr_slot]);
            hist_mem[wr_slot] = s;
            wr_slot++;
            if (wr_slot >= n)
                wr_slot = 0;
            // integer divide truncates toward zero
            last_out = sample_t'(run_sum / longint'(n));
        end
        return last_out;
    endfunction

    // ------------------------------------------------------------------
    // bookkeeping shared between stimulus, driver, receiver and monitor
    // ------------------------------------------------------------------
    sample_txn_t pending_samples[$];
    sample_t     filtered_expected[$];
    int          items_queued;
    int          items_accepted;
    int          forced_items;
    int          limiter_steps;
    int          average_steps;
    int          results_checked;
    int          mismatch_count;
    int          register_writes;

    // ------------------------------------------------------------------
    // sample driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    sample_txn_t next_txn;
    int          burst_left;
    int          gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_bus.valid     <= 1'b0;
            sample_bus.operation <= OP_STEP;
            sample_bus.sample    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // accepted transaction: predict its result now, in acceptance order
            if (sample_bus.valid && sample_bus.ready)
            begin
                filtered_expected.push_back(
                    next_filtered(sample_bus.operation, sample_bus.sample));
                items_accepted++;
                if (sample_bus.operation == OP_FORCE)
                    forced_items++;
                else if (cur_mode == MODE_LIMIT)
                    limiter_steps++;
                else
                    average_steps++;
            end
            // only one assignment to valid per edge, so a back-to-back item keeps it high
            if (!sample_bus.valid || sample_bus.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    sample_bus.valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    next_txn = pending_samples.pop_front();
                    sample_bus.valid     <= 1'b1;
                    sample_bus.operation <= next_txn.operation;
                    sample_bus.sample    <= next_txn.sample;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        // a third of the bursts run straight into the next one
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    sample_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: stall pattern of its own plus occasional long hold-off
    // ------------------------------------------------------------------
    int stall_pct;
    int pattern_left;
    int hold_left;
    int next_hold_at;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            stall_pct    = 0;
            pattern_left = 0;
            hold_left    = 0;
            next_hold_at = 300;
        end
        else
        begin
            if (hold_left == 0 && items_accepted >= next_hold_at)
            begin
                hold_left    = LONG_HOLD;
                next_hold_at = next_hold_at + HOLD_SPACING;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                // stall density changes from stretch to stretch, including none at all
                if (pattern_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        2:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                result_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: every result transaction against the oldest expectation
    // ------------------------------------------------------------------
    sample_t want_filtered;

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (filtered_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result transaction: filtered=%0d",
                             $time, result_bus.filtered);
            end
            else
            begin
                want_filtered = filtered_expected.pop_front();
                results_checked++;
                if (result_bus.filtered !== want_filtered)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] filtered mismatch: expected %0d (0x%08h) got %0d (0x%08h)",
                                 $time, want_filtered, want_filtered,
                                 result_bus.filtered, result_bus.filtered);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(logic op, sample_t s);
        sample_txn_t txn;
        txn.operation = op;
        txn.sample    = s;
        pending_samples.push_back(txn);
        items_queued++;
    endtask

    // block is idle once every queued item was accepted and every result came out
    task automatic wait_until_idle();
        while (items_accepted != items_queued || filtered_expected.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        apply_register_write(idx, data);
        register_writes++;
    endtask

    // extremes, small values near zero, values within +-2^19 and full-range noise
    function automatic sample_t random_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sample_t'(int'($urandom_range(0, 2000)) - 1000);
            3:       return sample_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] random_rate();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return RATE_MAX;
            2:       return RATE_W'($urandom_range(1, 1000));
            3:       return RATE_W'($urandom_range(1, 1 << 20));
            default: return RATE_W'($urandom);
        endcase
    endfunction

    // mostly short windows, now and then the largest one or an out-of-range code
    function automatic logic [WIN_CFG_W-1:0] random_window();
        case ($urandom_range(0, 7))
            0:       return WIN_CFG_W'(HIST_DEPTH);
            1:       return WIN_CFG_W'($urandom_range(0, 511));
            2:       return WIN_CFG_W'($urandom_range(0, 1));
            default: return WIN_CFG_W'($urandom_range(2, 8));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] cfg_word;
    int batch_len;

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FILTER_MODE;
        cfg_data  = '0;
        sample_bus.valid     = 1'b0;
        sample_bus.operation = OP_STEP;
        sample_bus.sample    = '0;
        result_bus.ready     = 1'b0;
        items_queued    = 0;
        items_accepted  = 0;
        forced_items    = 0;
        limiter_steps   = 0;
        average_steps   = 0;
        results_checked = 0;
        mismatch_count  = 0;
        register_writes = 0;

        // predictor at its reset state: limiter, zero step, window of two
        cur_mode   = MODE_LIMIT;
        cur_rate   = '0;
        cur_window = WIN_CFG_W'(MIN_WINDOW);
        force_history('0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // zero step: output holds unless the sample equals it
        write_register(CFG_RATE_STEP, '0);
        push_item(OP_STEP, 32'sd5);
        push_item(OP_STEP, 32'sd0);
        push_item(OP_FORCE, 32'sd100);
        push_item(OP_STEP, -32'sd7);
        push_item(OP_STEP, 32'sd100);
        wait_until_idle();

        // small step against full-scale swings, difference spans 33 bits
        write_register(CFG_RATE_STEP, 31'd1000);
        push_item(OP_STEP, SAMPLE_MAX);
        push_item(OP_STEP, SAMPLE_MIN);
        push_item(OP_FORCE, SAMPLE_MAX);
        push_item(OP_STEP, SAMPLE_MIN);
        wait_until_idle();

        // largest step, from one end of the range to the other
        write_register(CFG_RATE_STEP, RATE_MAX);
        push_item(OP_FORCE, SAMPLE_MIN);
        push_item(OP_STEP, SAMPLE_MAX);
        push_item(OP_STEP, SAMPLE_MIN);
        wait_until_idle();

        // write to an undecoded index changes nothing
        write_register(CFG_UNDECODED, 31'd5);
        push_item(OP_STEP, 32'sd0);
        wait_until_idle();

        // moving average, window code below the minimum is clamped to two
        write_register(CFG_FILTER_MODE, CFG_DATA_W'(MODE_AVG));
        write_register(CFG_WINDOW_SIZE, 31'd0);
        push_item(OP_STEP, SAMPLE_MAX);
        push_item(OP_STEP, SAMPLE_MAX);
        push_item(OP_STEP, SAMPLE_MIN);
        push_item(OP_FORCE, -32'sd5);
        push_item(OP_STEP, 32'sd3);
        wait_until_idle();

        // window code above the maximum is clamped to the full history
        write_register(CFG_WINDOW_SIZE, 31'd511);
        push_item(OP_STEP, SAMPLE_MAX);
        push_item(OP_FORCE, SAMPLE_MIN);
        push_item(OP_STEP, SAMPLE_MIN);
        push_item(OP_STEP, SAMPLE_MAX);
        wait_until_idle();

        // negative sum divided by two truncates toward zero
        write_register(CFG_WINDOW_SIZE, 31'd1);
        push_item(OP_STEP, -32'sd3);
        wait_until_idle();

        // back to the limiter: mode write clears the state, step stays
        write_register(CFG_FILTER_MODE, CFG_DATA_W'(MODE_LIMIT));
        push_item(OP_STEP, 32'sd7);

        // random phases: new settings between batches, random content within
        while (items_queued < TOTAL_ITEMS)
        begin
            wait_until_idle();
            if ($urandom_range(0, 3) != 0)
            begin
                cfg_word = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
                cfg_word[0] = 1'($urandom_range(0, 1));
                write_register(CFG_FILTER_MODE, cfg_word);
            end
            if ($urandom_range(0, 1) != 0)
                write_register(CFG_RATE_STEP, CFG_DATA_W'(random_rate()));
            if ($urandom_range(0, 1) != 0)
            begin
                cfg_word = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
                cfg_word[WIN_CFG_W-1:0] = random_window();
                write_register(CFG_WINDOW_SIZE, cfg_word);
            end
            batch_len = $urandom_range(20, 80);
            for (int i = 0; i < batch_len && items_queued < TOTAL_ITEMS; i++)
                push_item(($urandom_range(0, 15) == 0) ? OP_FORCE : OP_STEP, random_sample());
        end

        // drain, then give the block its full latency to show any stray result
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (filtered_expected.size() != 0)
        begin
            $display("%0d expected results never arrived", filtered_expected.size());
            mismatch_count = mismatch_count + filtered_expected.size();
        end

        $display("covered %0d transactions: %0d forced, %0d limiter steps, %0d average steps",
                 items_accepted, forced_items, limiter_steps, average_steps);
        $display("%0d register writes, %0d results checked, %0d failures",
                 register_writes, results_checked, mismatch_count);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout after %0d cycles", TIMEOUT_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

endmodule
